[rtl/tre_pkg.sv]
package tre_pkg;

  localparam int TILE_PIXELS = 16384;
  localparam int TILE_AW     = $clog2(TILE_PIXELS);

  localparam int COORD_W = 10;
  localparam int DIM_W   = 11;
  localparam int PIX_W   = 16;
  localparam int PROD_W  = COORD_W + DIM_W;
  localparam int ADDR_W  = PROD_W + 1;
  localparam int RPTR_W  = 2 * COORD_W;
  localparam int CFG_W   = DIM_W;

  localparam logic [1:0] FUNC_WIN   = 2'd0;
  localparam logic [1:0] FUNC_PIX   = 2'd1;
  localparam logic [1:0] FUNC_DRAIN = 2'd2;

  localparam logic [1:0] CFG_ROTATION     = 2'd0;
  localparam logic [1:0] CFG_PANEL_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_PANEL_HEIGHT = 2'd2;

  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  localparam logic [DIM_W-1:0] PANEL_RESET = 11'd412;

  typedef enum logic [1:0] {
    OP_WIN,
    OP_PIX,
    OP_DRAIN
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic [COORD_W-1:0] x2;
    logic [COORD_W-1:0] y2;
    logic [PIX_W-1:0]   pixel;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       rotation;
    logic [DIM_W-1:0] panel_width;
    logic [DIM_W-1:0] panel_height;
  } cfg_t;

endpackage

[rtl/tre_in_if.sv]
interface tre_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     func;
  logic [tre_pkg::COORD_W-1:0]    coord_x1;
  logic [tre_pkg::COORD_W-1:0]    coord_y1;
  logic [tre_pkg::COORD_W-1:0]    coord_x2;
  logic [tre_pkg::COORD_W-1:0]    coord_y2;
  logic [tre_pkg::PIX_W-1:0]      pixel_in;

  modport source (
    output valid, func, coord_x1, coord_y1, coord_x2, coord_y2, pixel_in,
    input  ready
  );
  modport sink (
    input  valid, func, coord_x1, coord_y1, coord_x2, coord_y2, pixel_in,
    output ready
  );
endinterface

[rtl/tre_out_if.sv]
interface tre_out_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [tre_pkg::COORD_W-1:0]    out_x1;
  logic [tre_pkg::COORD_W-1:0]    out_y1;
  logic [tre_pkg::COORD_W-1:0]    out_x2;
  logic [tre_pkg::COORD_W-1:0]    out_y2;
  logic [tre_pkg::PIX_W-1:0]      pixel_out;
  logic                           last;
  logic                           overflow;

  modport source (
    output valid, kind, out_x1, out_y1, out_x2, out_y2, pixel_out, last, overflow,
    input  ready
  );
  modport sink (
    input  valid, kind, out_x1, out_y1, out_x2, out_y2, pixel_out, last, overflow,
    output ready
  );
endinterface

[rtl/tre_front.sv]
module tre_front (
  input  logic          clk,
  input  logic          rst,
  tre_in_if.sink        in,
  output logic          q_valid,
  input  logic          q_ready,
  output tre_pkg::cmd_t q_cmd
);

  tre_pkg::cmd_t slot [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;
  logic          pop;
  logic          known;
  tre_pkg::cmd_t cmd_in;

  always_comb begin
    known       = 1'b1;
    cmd_in.op   = tre_pkg::OP_WIN;
    unique case (in.func)
      tre_pkg::FUNC_WIN:   cmd_in.op = tre_pkg::OP_WIN;
      tre_pkg::FUNC_PIX:   cmd_in.op = tre_pkg::OP_PIX;
      tre_pkg::FUNC_DRAIN: cmd_in.op = tre_pkg::OP_DRAIN;
      default:             known     = 1'b0;
    endcase
    cmd_in.x1    = in.coord_x1;
    cmd_in.y1    = in.coord_y1;
    cmd_in.x2    = in.coord_x2;
    cmd_in.y2    = in.coord_y2;
    cmd_in.pixel = in.pixel_in;
  end

  assign in.ready = (count != 2'd2);
  // unused function codes are taken and dropped here
  assign push     = in.valid && in.ready && known;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

[rtl/tre_back.sv]
module tre_back (
  input  logic          clk,
  input  logic          rst,
  input  tre_pkg::cfg_t cfg,
  input  logic          q_valid,
  output logic          q_ready,
  input  tre_pkg::cmd_t q_cmd,
  tre_out_if.source     out
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WMUL,
    S_PMUL,
    S_PWR,
    S_HDR,
    S_DRD,
    S_DOUT
  } state_t;

  localparam int CW = tre_pkg::COORD_W;
  localparam int DW = tre_pkg::DIM_W;

  state_t                    state;
  logic [CW-1:0]             win_left, win_top, win_right, win_bottom;
  logic [DW-1:0]             tile_w, tile_h;
  logic [tre_pkg::PROD_W-1:0] total;
  logic                      ovf;
  logic [CW-1:0]             col_count, row_count;
  logic [tre_pkg::RPTR_W-1:0] read_pointer;
  logic                      tile_ready;
  logic [tre_pkg::PIX_W-1:0] cur_pix;
  logic [CW-1:0]             mul_a;
  logic [DW-1:0]             mul_b;
  logic [CW-1:0]             add_off;
  logic [tre_pkg::PROD_W-1:0] prod;

  logic [tre_pkg::PIX_W-1:0] store [tre_pkg::TILE_PIXELS];
  logic [tre_pkg::PIX_W-1:0] rdata;

  logic                      out_valid;
  logic                      out_kind, out_last, out_ovf;
  logic [CW-1:0]             ox1, oy1, ox2, oy2;
  logic [tre_pkg::PIX_W-1:0] opix;

  logic                      out_free;
  logic                      out_load;
  logic [tre_pkg::ADDR_W-1:0] waddr;
  logic                      waddr_in;
  logic                      mem_we;
  logic                      mem_re;
  logic                      rp_in;
  logic [tre_pkg::PROD_W-1:0] rp_inc;
  logic                      drain_last;
  logic [DW-1:0]             col_inc, row_inc;
  logic [DW-1:0]             dw_w, dw_h;
  logic [CW-1:0]             x_rev, y_rev;
  logic [CW-1:0]             sel_a, sel_off;
  logic [DW-1:0]             sel_b;
  logic [CW-1:0]             hx1, hy1, hx2, hy2;
  logic [DW-1:0]             pw_m1, ph_m1;

  assign out_free = !out_valid || out.ready;
  assign out_load = out_free && ((state == S_HDR) || (state == S_DOUT));
  assign q_ready  = (state == S_IDLE);

  // tile size from the incoming window; inverted windows wrap
  assign dw_w = {1'b0, q_cmd.x2 - q_cmd.x1} + DW'(1);
  assign dw_h = {1'b0, q_cmd.y2 - q_cmd.y1} + DW'(1);

  // mirrored positions inside the tile
  assign x_rev = CW'(tile_w - DW'(1) - {1'b0, col_count});
  assign y_rev = CW'(tile_h - DW'(1) - {1'b0, row_count});

  always_comb begin
    unique case (cfg.rotation)
      tre_pkg::ROT_90:  begin sel_a = col_count; sel_b = tile_h; sel_off = y_rev;     end
      tre_pkg::ROT_180: begin sel_a = y_rev;     sel_b = tile_w; sel_off = x_rev;     end
      tre_pkg::ROT_270: begin sel_a = x_rev;     sel_b = tile_h; sel_off = row_count; end
      default:          begin sel_a = row_count; sel_b = tile_w; sel_off = col_count; end
    endcase
  end

  assign waddr    = {1'b0, prod} + tre_pkg::ADDR_W'(add_off);
  assign waddr_in = (waddr < tre_pkg::ADDR_W'(tre_pkg::TILE_PIXELS));
  assign mem_we   = (state == S_PWR) && waddr_in;
  assign mem_re   = (state == S_DRD);
  assign col_inc  = {1'b0, col_count} + DW'(1);
  assign row_inc  = {1'b0, row_count} + DW'(1);

  assign rp_in      = ({1'b0, read_pointer} < tre_pkg::PROD_W'(tre_pkg::TILE_PIXELS));
  assign rp_inc     = {1'b0, read_pointer} + tre_pkg::PROD_W'(1);
  assign drain_last = (rp_inc >= total);

  assign pw_m1 = cfg.panel_width - DW'(1);
  assign ph_m1 = cfg.panel_height - DW'(1);

  always_comb begin
    unique case (cfg.rotation)
      tre_pkg::ROT_90: begin
        hx1 = CW'(ph_m1 - {1'b0, win_bottom});
        hy1 = win_left;
        hx2 = CW'(ph_m1 - {1'b0, win_top});
        hy2 = win_right;
      end
      tre_pkg::ROT_180: begin
        hx1 = CW'(pw_m1 - {1'b0, win_right});
        hy1 = CW'(ph_m1 - {1'b0, win_bottom});
        hx2 = CW'(pw_m1 - {1'b0, win_left});
        hy2 = CW'(ph_m1 - {1'b0, win_top});
      end
      tre_pkg::ROT_270: begin
        hx1 = win_top;
        hy1 = CW'(pw_m1 - {1'b0, win_right});
        hx2 = win_bottom;
        hy2 = CW'(pw_m1 - {1'b0, win_left});
      end
      default: begin
        hx1 = win_left;
        hy1 = win_top;
        hx2 = win_right;
        hy2 = win_bottom;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[waddr[tre_pkg::TILE_AW-1:0]] <= cur_pix;
    end
    if (mem_re) begin
      rdata <= store[read_pointer[tre_pkg::TILE_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      win_left     <= '0;
      win_top      <= '0;
      win_right    <= '0;
      win_bottom   <= '0;
      tile_w       <= DW'(1);
      tile_h       <= DW'(1);
      total        <= tre_pkg::PROD_W'(1);
      ovf          <= 1'b0;
      col_count    <= '0;
      row_count    <= '0;
      read_pointer <= '0;
      tile_ready   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // hold a stalled result, load a new one when the slot frees
      out_valid <= out_load || (out_valid && !out.ready);
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            unique case (q_cmd.op)
              tre_pkg::OP_WIN: begin
                win_left     <= q_cmd.x1;
                win_top      <= q_cmd.y1;
                win_right    <= q_cmd.x2;
                win_bottom   <= q_cmd.y2;
                tile_w       <= dw_w;
                tile_h       <= dw_h;
                col_count    <= '0;
                row_count    <= '0;
                read_pointer <= '0;
                tile_ready   <= 1'b0;
                state        <= S_WMUL;
              end
              tre_pkg::OP_PIX: begin
                // drop pixels while a finished tile waits to drain
                if (!tile_ready) begin
                  cur_pix <= q_cmd.pixel;
                  mul_a   <= sel_a;
                  mul_b   <= sel_b;
                  add_off <= sel_off;
                  state   <= S_PMUL;
                end
              end
              default: begin
                if (tile_ready) state <= S_DRD;
              end
            endcase
          end
        end
        S_WMUL: begin
          total <= tile_w * tile_h;
          ovf   <= ((tile_w * tile_h) > tre_pkg::PROD_W'(tre_pkg::TILE_PIXELS));
          state <= S_IDLE;
        end
        S_PMUL: begin
          prod  <= mul_a * mul_b;
          state <= S_PWR;
        end
        S_PWR: begin
          if (col_inc < tile_w) begin
            col_count <= CW'(col_inc);
            state     <= S_IDLE;
          end else begin
            col_count <= '0;
            if (row_inc < tile_h) begin
              row_count <= CW'(row_inc);
              state     <= S_IDLE;
            end else begin
              row_count    <= '0;
              tile_ready   <= 1'b1;
              read_pointer <= '0;
              state        <= S_HDR;
            end
          end
        end
        S_HDR: begin
          if (out_free) begin
            out_kind  <= 1'b0;
            ox1       <= hx1;
            oy1       <= hy1;
            ox2       <= hx2;
            oy2       <= hy2;
            opix      <= '0;
            out_last  <= 1'b0;
            out_ovf   <= ovf;
            state     <= S_IDLE;
          end
        end
        S_DRD: begin
          state <= S_DOUT;
        end
        S_DOUT: begin
          if (out_free) begin
            out_kind  <= 1'b1;
            ox1       <= '0;
            oy1       <= '0;
            ox2       <= '0;
            oy2       <= '0;
            opix      <= rp_in ? rdata : '0;
            out_last  <= drain_last;
            out_ovf   <= ovf;
            if (drain_last) begin
              tile_ready   <= 1'b0;
              read_pointer <= '0;
            end else begin
              read_pointer <= tre_pkg::RPTR_W'(rp_inc);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out.valid     = out_valid;
  assign out.kind      = out_kind;
  assign out.out_x1    = ox1;
  assign out.out_y1    = oy1;
  assign out.out_x2    = ox2;
  assign out.out_y2    = oy2;
  assign out.pixel_out = opix;
  assign out.last      = out_last;
  assign out.overflow  = out_ovf;

endmodule

[rtl/tile_rotate_engine_unit.sv]
// Tile rotation engine for a display panel.
// Channel "in" takes requests: func 0 sets the logical window, func 1 delivers
// one pixel in logical row order, func 2 drains one rotated pixel; func 3 is
// taken and ignored. Channel "out" returns window headers (kind 0) and drained
// pixels (kind 1). The header follows the last pixel of the window; each drain
// of a completed tile returns one pixel in physical row order, last on the
// final one. The cfg port writes rotation, panel width and panel height; write
// it only while no request is in flight.
// A two-entry queue separates request intake from the execution sequencer, so
// "in" keeps accepting while a result waits on "out". The sequencer takes a
// window through a size multiply, a pixel through an address multiply and a
// store step, plus a header step when the tile completes, and a drain through
// a registered tile store read and an output step. It takes the next request
// from the queue only once it is back in idle. When "out" stalls, the
// sequencer holds at the result and the queue fills, then in.ready drops.
// Reset clears the window, counters and config to their defaults; the tile
// store is not cleared and needs no clearing pass.
module tile_rotate_engine_unit (
  input  logic                       clk,
  input  logic                       rst,
  tre_in_if.sink                     in,
  tre_out_if.source                  out,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [tre_pkg::CFG_W-1:0]  cfg_data
);

  tre_pkg::cfg_t cfg;
  logic          q_valid;
  logic          q_ready;
  tre_pkg::cmd_t q_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rotation     <= tre_pkg::ROT_0;
      cfg.panel_width  <= tre_pkg::PANEL_RESET;
      cfg.panel_height <= tre_pkg::PANEL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tre_pkg::CFG_ROTATION:     cfg.rotation     <= cfg_data[1:0];
        tre_pkg::CFG_PANEL_WIDTH:  cfg.panel_width  <= cfg_data;
        tre_pkg::CFG_PANEL_HEIGHT: cfg.panel_height <= cfg_data;
        default: ;
      endcase
    end
  end

  tre_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in      (in),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_cmd   (q_cmd)
  );

  tre_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_cmd   (q_cmd),
    .out     (out)
  );

endmodule

[rtl/tre_checker.sv]
module tre_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      kind,
  input logic                      last,
  input logic [tre_pkg::PIX_W-1:0] pixel_out,
  input logic [tre_pkg::COORD_W-1:0] out_x1,
  input logic [tre_pkg::COORD_W-1:0] out_y1,
  input logic [tre_pkg::COORD_W-1:0] out_x2,
  input logic [tre_pkg::COORD_W-1:0] out_y2
);

  // a stalled result stays valid and keeps its kind, pixel and last flag
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(pixel_out)
      && $stable(last))
    else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_header_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> !last && pixel_out == '0)
    else $error("header carries pixel data");

  a_pixel_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> out_x1 == '0 && out_y1 == '0 && out_x2 == '0 && out_y2 == '0)
    else $error("pixel result carries window corners");

endmodule

bind tile_rotate_engine_unit tre_checker u_tre_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out.valid),
  .out_ready (out.ready),
  .kind      (out.kind),
  .last      (out.last),
  .pixel_out (out.pixel_out),
  .out_x1    (out.out_x1),
  .out_y1    (out.out_y1),
  .out_x2    (out.out_x2),
  .out_y2    (out.out_y2)
);

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import tre_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int SETTLE_CYCLES    = 24;
  localparam int ITEMS_PER_PHASE  = 150;
  localparam int PHASES           = 8;
  localparam int MAX_REPORTS      = 10;
  localparam int LONG_HOLD_CYCLES = 600;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic [COORD_W-1:0] x2;
    logic [COORD_W-1:0] y2;
    logic [PIX_W-1:0]   pixel;
    logic               last;
    logic               overflow;
  } tile_result_t;

  class tile_rotation_tracker;
    logic [1:0]         rotation;
    logic [DIM_W-1:0]   panel_w;
    logic [DIM_W-1:0]   panel_h;
    logic [PIX_W-1:0]   store [TILE_PIXELS];
    logic [COORD_W-1:0] left, top, right, bottom;
    int unsigned        col, row, read_ptr;
    bit                 tile_done;
    tile_result_t       awaited [$];
    int                 failures;
    int                 reports;

    function new();
      rotation  = ROT_0;
      panel_w   = PANEL_RESET;
      panel_h   = PANEL_RESET;
      left      = '0;
      top       = '0;
      right     = '0;
      bottom    = '0;
      col       = 0;
      row       = 0;
      read_ptr  = 0;
      tile_done = 1'b0;
      failures  = 0;
      reports   = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_ROTATION:     rotation = data[1:0];
        CFG_PANEL_WIDTH:  panel_w = data;
        CFG_PANEL_HEIGHT: panel_h = data;
        default: ;
      endcase
    endfunction

    // inclusive extent; an inverted window wraps around
    function int unsigned span(logic [COORD_W-1:0] lo, logic [COORD_W-1:0] hi);
      logic [COORD_W-1:0] d;
      d = hi - lo;
      return 32'(d) + 1;
    endfunction

    function logic [COORD_W-1:0] fold(int unsigned v);
      return v[COORD_W-1:0];
    endfunction

    function bit oversized();
      return span(left, right) * span(top, bottom) > TILE_PIXELS;
    endfunction

    function tile_result_t remap_header();
      tile_result_t r;
      int unsigned pw, ph;
      pw = panel_w;
      ph = panel_h;
      r = '0;
      case (rotation)
        ROT_90: begin
          r.x1 = fold(ph - 1 - bottom);
          r.y1 = left;
          r.x2 = fold(ph - 1 - top);
          r.y2 = right;
        end
        ROT_180: begin
          r.x1 = fold(pw - 1 - right);
          r.y1 = fold(ph - 1 - bottom);
          r.x2 = fold(pw - 1 - left);
          r.y2 = fold(ph - 1 - top);
        end
        ROT_270: begin
          r.x1 = top;
          r.y1 = fold(pw - 1 - right);
          r.x2 = bottom;
          r.y2 = fold(pw - 1 - left);
        end
        default: begin
          r.x1 = left;
          r.y1 = top;
          r.x2 = right;
          r.y2 = bottom;
        end
      endcase
      r.overflow = oversized();
      return r;
    endfunction

    function int unsigned rotated_addr(int unsigned x, int unsigned y,
                                       int unsigned w, int unsigned h);
      case (rotation)
        ROT_90:  return x * h + (h - 1 - y);
        ROT_180: return (h - 1 - y) * w + (w - 1 - x);
        ROT_270: return (w - 1 - x) * h + y;
        default: return y * w + x;
      endcase
    endfunction

    function void note_request(logic [1:0] fn, logic [COORD_W-1:0] x1,
                               logic [COORD_W-1:0] y1, logic [COORD_W-1:0] x2,
                               logic [COORD_W-1:0] y2, logic [PIX_W-1:0] pix);
      int unsigned w, h, addr;
      tile_result_t r;
      w = span(left, right);
      h = span(top, bottom);
      case (fn)
        FUNC_WIN: begin
          left      = x1;
          top       = y1;
          right     = x2;
          bottom    = y2;
          col       = 0;
          row       = 0;
          read_ptr  = 0;
          tile_done = 1'b0;
        end
        FUNC_PIX: if (!tile_done) begin
          addr = rotated_addr(col, row, w, h);
          // drop pixels that land past the store
          if (addr < TILE_PIXELS) store[addr] = pix;
          if (col + 1 < w) begin
            col++;
          end else begin
            col = 0;
            if (row + 1 < h) begin
              row++;
            end else begin
              row       = 0;
              tile_done = 1'b1;
              read_ptr  = 0;
              awaited.push_back(remap_header());
            end
          end
        end
        FUNC_DRAIN: if (tile_done) begin
          r = '0;
          r.kind = 1'b1;
          if (read_ptr < TILE_PIXELS) r.pixel = store[read_ptr];
          r.overflow = oversized();
          if (read_ptr + 1 >= w * h) begin
            r.last    = 1'b1;
            tile_done = 1'b0;
            read_ptr  = 0;
          end else begin
            read_ptr++;
          end
          awaited.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function string show(tile_result_t r);
      return $sformatf("kind=%0d x1=%0d y1=%0d x2=%0d y2=%0d pixel=%h last=%0d overflow=%0d",
                       r.kind, r.x1, r.y1, r.x2, r.y2, r.pixel, r.last, r.overflow);
    endfunction

    function void check_output(tile_result_t got);
      tile_result_t want;
      if (awaited.size() == 0) begin
        failures++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("unexpected output: %s", show(got));
        end
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        failures++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("output mismatch: expected %s", show(want));
          $display("                 actual   %s", show(got));
        end
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  bit                 src_idle_on;
  bit                 sink_idle_on;
  int                 stall_trigger = 0;
  int                 stall_seen = 0;
  int                 hold_left = 0;
  int unsigned        cycle_count = 0;
  int                 useful_items = 0;

  tile_rotation_tracker tracker = new();

  tre_in_if  req_ch ();
  tre_out_if rsp_ch ();

  tile_rotate_engine_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in        (req_ch),
    .out       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: check, then pick ready for the next edge
  always @(posedge clk) begin : output_side
    tile_result_t got;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      got.kind     = rsp_ch.kind;
      got.x1       = rsp_ch.out_x1;
      got.y1       = rsp_ch.out_y1;
      got.x2       = rsp_ch.out_x2;
      got.y2       = rsp_ch.out_y2;
      got.pixel    = rsp_ch.pixel_out;
      got.last     = rsp_ch.last;
      got.overflow = rsp_ch.overflow;
      tracker.check_output(got);
    end
    if (stall_trigger != stall_seen) begin
      stall_seen = stall_trigger;
      hold_left  = LONG_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= !(sink_idle_on && $urandom_range(99) < 11);
    end
  end

  task automatic send_request(logic [1:0] fn, logic [COORD_W-1:0] x1,
                              logic [COORD_W-1:0] y1, logic [COORD_W-1:0] x2,
                              logic [COORD_W-1:0] y2, logic [PIX_W-1:0] pix);
    while (src_idle_on && $urandom_range(99) < 11) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.func     <= fn;
    req_ch.coord_x1 <= x1;
    req_ch.coord_y1 <= y1;
    req_ch.coord_x2 <= x2;
    req_ch.coord_y2 <= y2;
    req_ch.pixel_in <= pix;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    tracker.note_request(fn, x1, y1, x2, y2, pix);
    if (fn != FUNC_UNUSED) useful_items++;
  endtask

  task automatic send_op(logic [1:0] fn);
    send_request(fn, 10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                 16'($urandom));
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_reg(idx, data);
    @(posedge clk);
  endtask

  // drop valid, let every result drain, then give the sequencer time to empty
  task automatic wait_quiet();
    req_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_noise(logic [1:0] ignored_fn);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 3) send_op(ignored_fn);
    else if (pick < 5) send_op(FUNC_UNUSED);
  endtask

  function automatic int unsigned pick_dim();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 75) return $urandom_range(4, 1);
    if (pick < 97) return $urandom_range(12, 5);
    return $urandom_range(32, 13);
  endfunction

  task automatic run_tile();
    int unsigned w, h, count, i;
    logic [COORD_W-1:0] x1, y1;
    w  = pick_dim();
    h  = pick_dim();
    x1 = 10'($urandom);
    y1 = 10'($urandom);
    send_request(FUNC_WIN, x1, y1, 10'(x1 + w - 1), 10'(y1 + h - 1), 16'($urandom));
    count = w * h;
    // cut the tile short now and then; the next window restarts it
    if ($urandom_range(99) < 4) count = $urandom_range(count - 1);
    for (i = 0; i < count; i++) begin
      add_noise(FUNC_DRAIN);
      send_op(FUNC_PIX);
    end
    if (count < w * h) return;
    if ($urandom_range(99) < 10) send_op(FUNC_PIX);
    count = w * h;
    if ($urandom_range(99) < 4) count = $urandom_range(count - 1);
    for (i = 0; i < count; i++) begin
      add_noise(FUNC_PIX);
      send_op(FUNC_DRAIN);
    end
    if (count == w * h && $urandom_range(99) < 10) send_op(FUNC_DRAIN);
  endtask

  task automatic apply_phase_config(int phase);
    logic [1:0]       rot;
    logic [CFG_W-1:0] pw, ph;
    rot = 2'($urandom);
    pw  = 11'($urandom_range(1024, 1));
    ph  = 11'($urandom_range(1024, 1));
    case (phase)
      0: begin
        rot = ROT_0;
        pw  = PANEL_RESET;
        ph  = PANEL_RESET;
      end
      1: begin
        rot = ROT_90;
        pw  = 11'd1;
        ph  = 11'd1;
      end
      2: begin
        rot = ROT_180;
        pw  = 11'd1024;
        ph  = 11'd1024;
      end
      3: begin
        rot = ROT_270;
        pw  = 11'd1024;
        ph  = 11'd1;
      end
      default: ;
    endcase
    write_reg(CFG_ROTATION, rot);
    write_reg(CFG_PANEL_WIDTH, pw);
    write_reg(CFG_PANEL_HEIGHT, ph);
  endtask

  initial begin : stimulus
    int phase;
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.func     <= FUNC_WIN;
    req_ch.coord_x1 <= '0;
    req_ch.coord_y1 <= '0;
    req_ch.coord_x2 <= '0;
    req_ch.coord_y2 <= '0;
    req_ch.pixel_in <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_ROTATION;
    cfg_data        <= '0;
    src_idle_on     <= 1'b1;
    sink_idle_on    <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // drain with nothing stored, unused func code
    send_op(FUNC_DRAIN);
    send_op(FUNC_UNUSED);
    // reset window is one pixel: it completes at once
    send_request(FUNC_PIX, 10'd0, 10'd0, 10'd0, 10'd0, 16'hFFFF);
    send_request(FUNC_PIX, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 16'h0000);
    send_op(FUNC_DRAIN);
    send_op(FUNC_DRAIN);
    // inverted window wraps to 2x2; restart it half way
    send_request(FUNC_WIN, 10'd1023, 10'd1023, 10'd0, 10'd0, 16'h0000);
    send_request(FUNC_PIX, 10'd0, 10'd0, 10'd0, 10'd0, 16'h1234);
    send_request(FUNC_PIX, 10'd0, 10'd0, 10'd0, 10'd0, 16'h8000);
    send_request(FUNC_WIN, 10'd1023, 10'd1023, 10'd0, 10'd0, 16'hFFFF);
    send_request(FUNC_PIX, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0001);
    send_request(FUNC_PIX, 10'd0, 10'd0, 10'd0, 10'd0, 16'hFFFE);
    send_request(FUNC_PIX, 10'd0, 10'd0, 10'd0, 10'd0, 16'hA5A5);
    send_request(FUNC_PIX, 10'd0, 10'd0, 10'd0, 10'd0, 16'h5A5A);
    repeat (4) send_op(FUNC_DRAIN);
    wait_quiet();

    // swap rotation mid-tile on a single row, where 0 and 90 degrees store alike
    write_reg(CFG_ROTATION, ROT_0);
    send_request(FUNC_WIN, 10'd5, 10'd7, 10'd12, 10'd7, 16'($urandom));
    repeat (4) send_op(FUNC_PIX);
    wait_quiet();
    write_reg(CFG_ROTATION, ROT_90);
    repeat (4) send_op(FUNC_PIX);
    repeat (8) send_op(FUNC_DRAIN);

    // full-width row and a window past the store capacity, each cut short
    send_request(FUNC_WIN, 10'd0, 10'd1023, 10'd1023, 10'd1023, 16'($urandom));
    repeat (8) send_op(FUNC_PIX);
    wait_quiet();
    write_reg(CFG_ROTATION, ROT_270);
    // at 270 degrees the first column lands past the store and is dropped
    send_request(FUNC_WIN, 10'd0, 10'd0, 10'd128, 10'd127, 16'($urandom));
    repeat (8) send_op(FUNC_PIX);

    for (phase = 0; phase < PHASES; phase++) begin
      wait_quiet();
      apply_phase_config(phase);
      useful_items = 0;
      if (phase == 2) stall_trigger <= stall_trigger + 1;
      if (phase == 3) begin
        repeat (3) run_tile();
        wait_quiet();
      end
      if (phase == 4) begin
        src_idle_on  <= 1'b0;
        sink_idle_on <= 1'b0;
      end
      if (phase == 5) begin
        src_idle_on  <= 1'b1;
        sink_idle_on <= 1'b1;
      end
      while (useful_items < ITEMS_PER_PHASE) run_tile();
    end

    wait_quiet();
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
rtl/tre_pkg.sv
rtl/tre_in_if.sv
rtl/tre_out_if.sv
rtl/tre_front.sv
rtl/tre_back.sv
rtl/tile_rotate_engine_unit.sv
rtl/tre_checker.sv
bench/tb_top.sv
